FILE: rtl/bmsi_pkg.sv
// ============================================================================
// bmsi_pkg
// Shared types and constants for the banked mapper with scanline IRQ.
// ============================================================================
`default_nettype none

package bmsi_pkg;

    // Default parameter values
    localparam int PRG_ADDR_BITS_DEF = 19;
    localparam int CHR_ADDR_BITS_DEF = 18;
    localparam int EDGE_HOLD_DEF     = 16;

    // Fixed field widths
    localparam int PRG_OUT_W  = 19;
    localparam int CHR_OUT_W  = 18;
    localparam int SIZE_W     = 5;
    localparam int TMO_W      = 5;
    localparam int IN_W       = 40;
    localparam int OUT_W      = 48;
    localparam int CFG_ADDR_W = 3;

    // Window geometry
    localparam int PRG_PAGE_BITS = 13;
    localparam int CHR_PAGE_BITS = 10;
    localparam int PRG_MIN_LOG2  = 14;
    localparam int CHR_MIN_LOG2  = 11;
    localparam logic [7:0] PRG_FIXED_BANK = 8'hFE;

    // Configuration reset values
    localparam logic [SIZE_W-1:0] PRG_SIZE_RST = 5'd19;
    localparam logic [SIZE_W-1:0] CHR_SIZE_RST = 5'd18;

    // Configuration register indexes
    typedef enum logic {
        CFG_PRG_SIZE = 1'b0,
        CFG_CHR_SIZE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LATCH = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // CPU write register groups, address bits 14..13
    typedef enum logic [1:0] {
        WIN_BANK   = 2'd0,
        WIN_MIRROR = 2'd1,
        WIN_IRQ    = 2'd2,
        WIN_IRQ_EN = 2'd3
    } t_win;

    typedef logic [7:0][7:0] t_bank_regs;

    typedef struct packed {
        t_bank_regs bank;
        logic       prg_swap;
        logic       chr_swap;
    } t_map_state;

endpackage

`default_nettype wire

FILE: rtl/bmsi_regs.sv
// ============================================================================
// bmsi_regs
// Mapper register file, A12 edge filter and scanline IRQ counter.
// ============================================================================
`default_nettype none

module bmsi_regs #(
    parameter int EDGE_HOLD = bmsi_pkg::EDGE_HOLD_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire bmsi_pkg::t_op         i_op,
    input  wire logic [15:0]           i_cpu_address,
    input  wire logic [7:0]            i_write_data,
    input  wire logic [13:0]           i_video_address,
    output bmsi_pkg::t_map_state       o_map,
    output logic                       o_irq_next,
    output logic                       o_mirror_next
);
    import bmsi_pkg::*;

    localparam logic [TMO_W-1:0] HOLD = TMO_W'(EDGE_HOLD);

    t_bank_regs       r_bank, n_bank;
    logic [2:0]       r_bank_sel, n_bank_sel;
    logic             r_prg_swap, n_prg_swap;
    logic             r_chr_swap, n_chr_swap;
    logic [7:0]       r_irq_latch, n_irq_latch;
    logic [7:0]       r_irq_cnt, n_irq_cnt;
    logic             r_reload, n_reload;
    logic             r_irq_en, n_irq_en;
    logic             r_irq_pend, n_irq_pend;
    logic             r_edge_seen, n_edge_seen;
    logic [TMO_W-1:0] r_edge_to, n_edge_to;
    logic             r_mirror, n_mirror;

    t_win             win;
    logic             odd;

    assign win = t_win'(i_cpu_address[14:13]);
    assign odd = i_cpu_address[0];

    always_comb begin
        n_bank      = r_bank;
        n_bank_sel  = r_bank_sel;
        n_prg_swap  = r_prg_swap;
        n_chr_swap  = r_chr_swap;
        n_irq_latch = r_irq_latch;
        n_irq_cnt   = r_irq_cnt;
        n_reload    = r_reload;
        n_irq_en    = r_irq_en;
        n_irq_pend  = r_irq_pend;
        n_edge_seen = r_edge_seen;
        n_edge_to   = r_edge_to;
        n_mirror    = r_mirror;
        if (i_en) begin
            unique case (i_op)
                OP_WRITE: begin
                    if (i_cpu_address[15]) begin
                        unique case (win)
                            WIN_BANK: begin
                                if (odd) begin
                                    n_bank[r_bank_sel] = i_write_data;
                                end else begin
                                    n_bank_sel = i_write_data[2:0];
                                    n_prg_swap = i_write_data[6];
                                    n_chr_swap = i_write_data[7];
                                end
                            end
                            WIN_MIRROR: begin
                                if (!odd) n_mirror = i_write_data[0];
                            end
                            WIN_IRQ: begin
                                if (odd) n_reload = 1'b1;
                                else n_irq_latch = i_write_data;
                            end
                            WIN_IRQ_EN: begin
                                if (odd) begin
                                    n_irq_en = 1'b1;
                                end else begin
                                    n_irq_en   = 1'b0;
                                    n_irq_pend = 1'b0;
                                end
                            end
                        endcase
                    end
                end
                OP_LATCH: begin
                    if (!i_video_address[12]) begin
                        // saturating low timeout
                        n_edge_to = (r_edge_to != '0) ? r_edge_to - TMO_W'(1) : '0;
                        if (n_edge_to == '0) n_edge_seen = 1'b0;
                    end else begin
                        n_edge_to = HOLD;
                        if (!r_edge_seen) begin
                            n_edge_seen = 1'b1;
                            if (r_reload || r_irq_cnt == 8'd0) begin
                                n_reload  = 1'b0;
                                n_irq_cnt = r_irq_latch;
                            end else begin
                                n_irq_cnt = r_irq_cnt - 8'd1;
                            end
                            if (n_irq_cnt == 8'd0 && r_irq_en) n_irq_pend = 1'b1;
                        end
                    end
                end
                OP_READ, OP_NONE: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank      <= '0;
            r_bank_sel  <= '0;
            r_prg_swap  <= 1'b0;
            r_chr_swap  <= 1'b0;
            r_irq_latch <= '0;
            r_irq_cnt   <= '0;
            r_reload    <= 1'b0;
            r_irq_en    <= 1'b0;
            r_irq_pend  <= 1'b0;
            r_edge_seen <= 1'b0;
            r_edge_to   <= '0;
            r_mirror    <= 1'b0;
        end else begin
            r_bank      <= n_bank;
            r_bank_sel  <= n_bank_sel;
            r_prg_swap  <= n_prg_swap;
            r_chr_swap  <= n_chr_swap;
            r_irq_latch <= n_irq_latch;
            r_irq_cnt   <= n_irq_cnt;
            r_reload    <= n_reload;
            r_irq_en    <= n_irq_en;
            r_irq_pend  <= n_irq_pend;
            r_edge_seen <= n_edge_seen;
            r_edge_to   <= n_edge_to;
            r_mirror    <= n_mirror;
        end
    end

    assign o_map.bank     = r_bank;
    assign o_map.prg_swap = r_prg_swap;
    assign o_map.chr_swap = r_chr_swap;
    assign o_irq_next     = n_irq_en & n_irq_pend;
    assign o_mirror_next  = n_mirror;

endmodule

`default_nettype wire

FILE: rtl/bmsi_xlate.sv
// ============================================================================
// bmsi_xlate
// Program and character ROM address translation through the bank windows.
// ============================================================================
`default_nettype none

module bmsi_xlate #(
    parameter int PRG_ADDR_BITS = bmsi_pkg::PRG_ADDR_BITS_DEF,
    parameter int CHR_ADDR_BITS = bmsi_pkg::CHR_ADDR_BITS_DEF
) (
    input  wire bmsi_pkg::t_map_state            i_map,
    input  wire logic [bmsi_pkg::SIZE_W-1:0]     i_prg_size,
    input  wire logic [bmsi_pkg::SIZE_W-1:0]     i_chr_size,
    input  wire bmsi_pkg::t_op                   i_op,
    input  wire logic [15:0]                     i_cpu_address,
    input  wire logic [13:0]                     i_video_address,
    output logic                                 o_prg_hit,
    output logic [bmsi_pkg::PRG_OUT_W-1:0]       o_prg_address,
    output logic                                 o_chr_hit,
    output logic [bmsi_pkg::CHR_OUT_W-1:0]       o_chr_address
);
    import bmsi_pkg::*;

    localparam int PW = PRG_ADDR_BITS;
    localparam int CW = CHR_ADDR_BITS;
    localparam logic [SIZE_W-1:0] PRG_LO = SIZE_W'(PRG_MIN_LOG2);
    localparam logic [SIZE_W-1:0] PRG_HI = SIZE_W'(PRG_ADDR_BITS);
    localparam logic [SIZE_W-1:0] CHR_LO = SIZE_W'(CHR_MIN_LOG2);
    localparam logic [SIZE_W-1:0] CHR_HI = SIZE_W'(CHR_ADDR_BITS);

    logic [SIZE_W-1:0] prg_n, chr_n;
    logic [PW-1:0]     prg_mask, prg_fixed, prg_b6, prg_b7, prg_base, prg_addr;
    logic [CW-1:0]     chr_mask, chr_base, chr_addr;
    logic [2:0]        slot;
    logic [7:0]        chr_bank;

    always_comb begin
        if (i_prg_size < PRG_LO)      prg_n = PRG_LO;
        else if (i_prg_size > PRG_HI) prg_n = PRG_HI;
        else                          prg_n = i_prg_size;
        if (i_chr_size < CHR_LO)      chr_n = CHR_LO;
        else if (i_chr_size > CHR_HI) chr_n = CHR_HI;
        else                          chr_n = i_chr_size;
        for (int b = 0; b < PW; b++) begin
            prg_mask[b] = (b >= PRG_PAGE_BITS) && (SIZE_W'(b) < prg_n);
        end
        for (int b = 0; b < CW; b++) begin
            chr_mask[b] = (b >= CHR_PAGE_BITS) && (SIZE_W'(b) < chr_n);
        end
    end

    assign prg_fixed = PW'({PRG_FIXED_BANK, 13'b0}) & prg_mask;
    assign prg_b6    = PW'({i_map.bank[6], 13'b0}) & prg_mask;
    assign prg_b7    = PW'({i_map.bank[7], 13'b0}) & prg_mask;

    always_comb begin
        case (i_cpu_address[14:13])
            2'd0:    prg_base = i_map.prg_swap ? prg_fixed : prg_b6;
            2'd1:    prg_base = prg_b7;
            2'd2:    prg_base = i_map.prg_swap ? prg_b6 : prg_fixed;
            default: prg_base = prg_mask;
        endcase
    end

    assign prg_addr = prg_base | PW'(i_cpu_address[12:0]);

    assign slot = i_video_address[12:10] ^ {i_map.chr_swap, 2'b00};

    always_comb begin
        if (!slot[2]) begin
            chr_bank = i_map.bank[{2'b00, slot[1]}] & 8'hFE;
            chr_base = CW'({chr_bank, 10'b0}) & chr_mask;
            if (slot[0]) chr_base = chr_base | CW'(11'h400);
        end else begin
            chr_bank = i_map.bank[{1'b0, slot[1:0]} + 3'd2];
            chr_base = CW'({chr_bank, 10'b0}) & chr_mask;
        end
    end

    assign chr_addr = chr_base | CW'(i_video_address[9:0]);

    assign o_prg_hit     = (i_op == OP_READ) && i_cpu_address[15];
    assign o_prg_address = o_prg_hit ? PRG_OUT_W'(prg_addr) : '0;
    assign o_chr_hit     = (i_op == OP_LATCH) && !i_video_address[13];
    assign o_chr_address = o_chr_hit ? CHR_OUT_W'(chr_addr) : '0;

endmodule

`default_nettype wire

FILE: rtl/bmsi_outbuf.sv
// ============================================================================
// bmsi_outbuf
// Two-entry result buffer: output register plus skid register.
// ============================================================================
`default_nettype none

module bmsi_outbuf #(
    parameter int W = bmsi_pkg::OUT_W
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [W-1:0]      o_data
);
    logic         r_out_vld, r_skid_vld;
    logic [W-1:0] r_out, r_skid;
    logic         push, load_out;

    assign o_ready  = !r_skid_vld;
    assign push     = i_valid && o_ready;
    assign load_out = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld  <= r_skid_vld || push;
            r_skid_vld <= 1'b0;
        end else if (push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_skid_vld ? r_skid : i_data;
        end else if (push) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/banked_mapper_with_scanline_irq.sv
// ============================================================================
// banked_mapper_with_scanline_irq
// Cartridge bank mapper with A12-filtered scanline IRQ counter.
// ============================================================================
// Takes one bus request per cycle and returns exactly one result per request,
// registered through a two-entry output buffer; the input stalls only when
// both entries are full. Requests are CPU reads (program ROM
// translation), CPU writes (mapper registers) and video address latches
// (character ROM translation and scanline counter clocking). The IRQ and
// mirroring flags in a result reflect the state after that request is applied.
// ROM size registers at APB addresses 0x0 and 0x4 set the bank masks.
`default_nettype none

module banked_mapper_with_scanline_irq #(
    parameter int PRG_ADDR_BITS = bmsi_pkg::PRG_ADDR_BITS_DEF,
    parameter int CHR_ADDR_BITS = bmsi_pkg::CHR_ADDR_BITS_DEF,
    parameter int EDGE_HOLD     = bmsi_pkg::EDGE_HOLD_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // APB configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bmsi_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // request stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // cpu_address[15:0], write_data[23:16], video_address[37:24], zero pad
    input  wire logic [bmsi_pkg::IN_W-1:0]      s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]                     s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // prg_rom_hit[0], prg_rom_address[19:1], chr_rom_hit[20],
    // chr_rom_address[38:21], irq_out[39], mirror_is_horizontal[40], zero pad
    output logic [bmsi_pkg::OUT_W-1:0]          m_tdata
);
    import bmsi_pkg::*;

    logic [SIZE_W-1:0]    r_prg_size, r_chr_size;
    logic                 cfg_wr;
    t_cfg_idx             cfg_idx;

    t_op                  op;
    logic [15:0]          cpu_address;
    logic [7:0]           write_data;
    logic [13:0]          video_address;
    logic                 accept;

    t_map_state           map;
    logic                 irq_next, mirror_next;
    logic                 prg_hit, chr_hit;
    logic [PRG_OUT_W-1:0] prg_address;
    logic [CHR_OUT_W-1:0] chr_address;
    logic [OUT_W-1:0]     result;

    // configuration
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_cfg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_size <= PRG_SIZE_RST;
            r_chr_size <= CHR_SIZE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                CFG_PRG_SIZE: r_prg_size <= pwdata[SIZE_W-1:0];
                CFG_CHR_SIZE: r_chr_size <= pwdata[SIZE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            CFG_PRG_SIZE: prdata = {{(32-SIZE_W){1'b0}}, r_prg_size};
            CFG_CHR_SIZE: prdata = {{(32-SIZE_W){1'b0}}, r_chr_size};
        endcase
    end

    // request unpack
    assign op            = t_op'(s_tuser);
    assign cpu_address   = s_tdata[15:0];
    assign write_data    = s_tdata[23:16];
    assign video_address = s_tdata[37:24];
    assign accept        = s_tvalid && s_tready;

    bmsi_regs #(
        .EDGE_HOLD (EDGE_HOLD)
    ) u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (accept),
        .i_op            (op),
        .i_cpu_address   (cpu_address),
        .i_write_data    (write_data),
        .i_video_address (video_address),
        .o_map           (map),
        .o_irq_next      (irq_next),
        .o_mirror_next   (mirror_next)
    );

    bmsi_xlate #(
        .PRG_ADDR_BITS (PRG_ADDR_BITS),
        .CHR_ADDR_BITS (CHR_ADDR_BITS)
    ) u_xlate (
        .i_map           (map),
        .i_prg_size      (r_prg_size),
        .i_chr_size      (r_chr_size),
        .i_op            (op),
        .i_cpu_address   (cpu_address),
        .i_video_address (video_address),
        .o_prg_hit       (prg_hit),
        .o_prg_address   (prg_address),
        .o_chr_hit       (chr_hit),
        .o_chr_address   (chr_address)
    );

    assign result = {7'b0, mirror_next, irq_next, chr_address, chr_hit,
                     prg_address, prg_hit};

    bmsi_outbuf #(
        .W (OUT_W)
    ) u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_data  (result),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: banked mapper with scanline IRQ
// Sends CPU reads, CPU writes and video address latches into the mapper over
// the request stream, with random gaps and backpressure. A built-in model of
// the bank registers, ROM windows, A12 filter and scanline counter predicts
// each result, and a checker compares the results in order, field by field.
// ROM size registers are swept through in-range and out-of-range values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import bmsi_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        mirror_h;
        logic        irq;
        logic [17:0] chr_addr;
        logic        chr_hit;
        logic [18:0] prg_addr;
        logic        prg_hit;
    } t_map_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    // cpu_address[15:0], write_data[23:16], video_address[37:24], zero pad
    logic [IN_W-1:0]       s_tdata;
    // opcode[1:0]
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // prg_rom_hit[0], prg_rom_address[19:1], chr_rom_hit[20],
    // chr_rom_address[38:21], irq_out[39], mirror_is_horizontal[40], zero pad
    logic [OUT_W-1:0]      m_tdata;

    banked_mapper_with_scanline_irq dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // mapper model state
    logic [4:0]  cfg_prg_log2;
    logic [4:0]  cfg_chr_log2;
    logic [7:0]  mp_bank [8];
    logic [2:0]  mp_bank_sel;
    logic        mp_prg_swap;
    logic        mp_chr_swap;
    logic [7:0]  mp_irq_latch;
    logic [7:0]  mp_irq_count;
    logic        mp_reload;
    logic        mp_irq_en;
    logic        mp_irq_pend;
    logic        mp_a12_seen;
    logic [4:0]  mp_a12_timer;
    logic        mp_mirror_h;

    t_map_result expected_results[$];
    t_map_result got_result;
    t_map_result want_result;
    int          fail_count;
    int          requests_sent;
    int          cycle_count;
    int unsigned tx_idle_max;
    int unsigned rx_idle_max;
    int unsigned long_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_map_result predict_access(t_op op, logic [15:0] ca, logic [7:0] wd,
                                                   logic [13:0] va);
        t_map_result r;
        logic [31:0] pm;
        logic [31:0] cm;
        logic [31:0] base;
        logic [31:0] fixed_base;
        logic [31:0] b6;
        logic [31:0] b7;
        int          n;
        logic [2:0]  slot;
        r = '0;
        case (op)
            OP_READ: begin
                if (ca[15]) begin
                    n = (cfg_prg_log2 < PRG_MIN_LOG2) ? PRG_MIN_LOG2 :
                        (cfg_prg_log2 > PRG_ADDR_BITS_DEF) ? PRG_ADDR_BITS_DEF : cfg_prg_log2;
                    pm = ((32'd1 << n) - 32'd1) & ~32'h1FFF;
                    fixed_base = (32'(PRG_FIXED_BANK) << 13) & pm;
                    b6 = (32'(mp_bank[6]) << 13) & pm;
                    b7 = (32'(mp_bank[7]) << 13) & pm;
                    // read windows decode the same address bits as the write groups
                    case (t_win'(ca[14:13]))
                        WIN_BANK:   base = mp_prg_swap ? fixed_base : b6;
                        WIN_MIRROR: base = b7;
                        WIN_IRQ:    base = mp_prg_swap ? b6 : fixed_base;
                        default:    base = pm;
                    endcase
                    r.prg_hit = 1'b1;
                    r.prg_addr = 19'(32'(ca[12:0]) | base);
                end
            end
            OP_WRITE: begin
                if (ca[15]) begin
                    case (t_win'(ca[14:13]))
                        WIN_BANK: begin
                            if (ca[0]) begin
                                mp_bank[mp_bank_sel] = wd;
                            end else begin
                                mp_bank_sel = wd[2:0];
                                mp_prg_swap = wd[6];
                                mp_chr_swap = wd[7];
                            end
                        end
                        WIN_MIRROR: begin
                            if (!ca[0]) mp_mirror_h = wd[0];
                        end
                        WIN_IRQ: begin
                            if (ca[0]) mp_reload = 1'b1;
                            else mp_irq_latch = wd;
                        end
                        default: begin
                            if (ca[0]) begin
                                mp_irq_en = 1'b1;
                            end else begin
                                mp_irq_en = 1'b0;
                                mp_irq_pend = 1'b0;
                            end
                        end
                    endcase
                end
            end
            OP_LATCH: begin
                // A12 filter: low latches count the timeout down, saturating at zero
                if (!va[12]) begin
                    if (mp_a12_timer != 0) mp_a12_timer--;
                    if (mp_a12_timer == 0) mp_a12_seen = 1'b0;
                end else begin
                    mp_a12_timer = 5'(EDGE_HOLD_DEF & 31);
                    if (!mp_a12_seen) begin
                        mp_a12_seen = 1'b1;
                        if (mp_reload || mp_irq_count == 0) begin
                            mp_reload = 1'b0;
                            mp_irq_count = mp_irq_latch;
                        end else begin
                            mp_irq_count--;
                        end
                        if (mp_irq_count == 0 && mp_irq_en) mp_irq_pend = 1'b1;
                    end
                end
                if (!va[13]) begin
                    n = (cfg_chr_log2 < CHR_MIN_LOG2) ? CHR_MIN_LOG2 :
                        (cfg_chr_log2 > CHR_ADDR_BITS_DEF) ? CHR_ADDR_BITS_DEF : cfg_chr_log2;
                    cm = ((32'd1 << n) - 32'd1) & ~32'h03FF;
                    slot = va[12:10];
                    if (mp_chr_swap) slot = slot ^ 3'd4;
                    if (!slot[2]) begin
                        base = (32'(mp_bank[slot >> 1] & 8'hFE) << 10) & cm;
                        if (slot[0]) base = base | 32'h400;
                    end else begin
                        base = (32'(mp_bank[slot - 3'd2]) << 10) & cm;
                    end
                    r.chr_hit = 1'b1;
                    r.chr_addr = 18'(32'(va[9:0]) | base);
                end
            end
            default: ;
        endcase
        r.irq = mp_irq_en & mp_irq_pend;
        r.mirror_h = mp_mirror_h;
        return r;
    endfunction

    function automatic logic [15:0] reg_addr(t_win w, logic odd);
        return {1'b1, w, 12'($urandom), odd};
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            got_result = t_map_result'(m_tdata[40:0]);
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: 0x%0h", m_tdata);
                fail_count++;
            end else begin
                want_result = expected_results.pop_front();
                check_field("prg_rom_hit", want_result.prg_hit, got_result.prg_hit);
                check_field("prg_rom_address", want_result.prg_addr, got_result.prg_addr);
                check_field("chr_rom_hit", want_result.chr_hit, got_result.chr_hit);
                check_field("chr_rom_address", want_result.chr_addr, got_result.chr_addr);
                check_field("irq_out", want_result.irq, got_result.irq);
                check_field("mirror_is_horizontal", want_result.mirror_h,
                            got_result.mirror_h);
            end
        end
    end

    // result receiver
    initial begin : receiver
        int unsigned rx_gap;
        int unsigned hold_n;
        m_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (long_hold != 0) begin
                hold_n = long_hold;
                long_hold = 0;
                m_tready = 1'b0;
                repeat (hold_n) @(negedge i_clk);
            end
            rx_gap = $urandom_range(0, rx_idle_max);
            if (rx_gap != 0) begin
                m_tready = 1'b0;
                repeat (rx_gap) @(negedge i_clk);
            end
            m_tready = 1'b1;
            do @(posedge i_clk); while (!(m_tvalid && m_tready));
            @(negedge i_clk);
        end
    end

    task automatic issue(t_op op, logic [15:0] ca, logic [7:0] wd, logic [13:0] va);
        int unsigned gap;
        s_tdata = {2'b00, va, wd, ca};
        s_tuser = op;
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        expected_results.push_back(predict_access(op, ca, wd, va));
        requests_sent++;
        @(negedge i_clk);
        gap = $urandom_range(0, tx_idle_max);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_rom_size(t_cfg_idx idx, logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = CFG_ADDR_W'(4 * int'(idx));
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            CFG_PRG_SIZE: cfg_prg_log2 = value[4:0];
            default:      cfg_chr_log2 = value[4:0];
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic issue_random_access();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            issue(OP_READ, 16'($urandom), 8'($urandom), 14'($urandom));
        end else if (pick < 60) begin
            issue(OP_WRITE, ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 16'h7FFF)) :
                  16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom), 14'($urandom));
        end else if (pick < 95) begin
            issue(OP_LATCH, 16'($urandom), 8'($urandom), 14'($urandom));
        end else begin
            issue(OP_NONE, 16'($urandom), 8'($urandom), 14'($urandom));
        end
    endtask

    task automatic test_directed();
        issue(OP_READ, 16'h8000, 8'h00, 14'h0000);
        issue(OP_READ, 16'hFFFF, 8'hFF, 14'h3FFF);
        issue(OP_READ, 16'h7FFF, 8'hFF, 14'h3FFF);
        issue(OP_NONE, 16'hFFFF, 8'hFF, 14'h3FFF);
        issue(OP_LATCH, 16'h0000, 8'h00, 14'h0000);     // timeout already at zero
        issue(OP_LATCH, 16'h0000, 8'h00, 14'h3FFF);     // above pattern space, A12 high
        issue(OP_WRITE, 16'h8000, 8'hC6, 14'h0000);     // select bank 6, both swaps
        issue(OP_WRITE, 16'h8001, 8'hFF, 14'h0000);
        issue(OP_WRITE, 16'h8000, 8'h07, 14'h0000);
        issue(OP_WRITE, 16'h8001, 8'h81, 14'h0000);
        issue(OP_READ, 16'h8000, 8'h00, 14'h0000);
        issue(OP_READ, 16'hC123, 8'h00, 14'h0000);
        issue(OP_READ, 16'hA000, 8'h00, 14'h0000);
        issue(OP_READ, 16'hDFFF, 8'h00, 14'h0000);
        issue(OP_WRITE, 16'hA000, 8'h01, 14'h0000);     // horizontal mirroring
        issue(OP_WRITE, 16'hA001, 8'h00, 14'h0000);     // RAM protect, ignored
        issue(OP_WRITE, 16'h7FFE, 8'hFF, 14'h0000);     // below mapper space
        issue(OP_WRITE, 16'hC000, 8'h00, 14'h0000);
        issue(OP_WRITE, 16'hC001, 8'h00, 14'h0000);
        issue(OP_WRITE, 16'hE001, 8'h00, 14'h0000);
        issue(OP_LATCH, 16'h0000, 8'h00, 14'h1FFF);
        issue(OP_WRITE, 16'hE000, 8'h00, 14'h0000);
        issue(OP_LATCH, 16'h0000, 8'h00, 14'h0C00);
        issue(OP_WRITE, 16'h8000, 8'h00, 14'h0000);
        issue(OP_LATCH, 16'h0000, 8'h00, 14'h1400);
    endtask

    task automatic test_rom_sizes();
        int prg_set [9] = '{19, 14, 0, 31, 13, 20, 16, 17, 15};
        int chr_set [9] = '{18, 11, 0, 31, 10, 19, 15, 12, 16};
        int i;
        int b;
        for (i = 0; i < 9; i++) begin
            settle();
            write_rom_size(CFG_PRG_SIZE, 32'(prg_set[i]));
            write_rom_size(CFG_CHR_SIZE, 32'(chr_set[i]));
            for (b = 0; b < 8; b++) begin
                issue(OP_WRITE, reg_addr(WIN_BANK, 1'b0),
                      {$urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1, 3'($urandom), 3'(b)},
                      14'($urandom));
                issue(OP_WRITE, reg_addr(WIN_BANK, 1'b1), 8'($urandom), 14'($urandom));
            end
            repeat (10) issue(OP_READ, 16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom),
                              14'($urandom));
            repeat (10) issue(OP_LATCH, 16'($urandom), 8'($urandom),
                              14'($urandom_range(0, 14'h1FFF)));
        end
    endtask

    task automatic test_scanline_irq();
        int lines;
        for (lines = 0; lines < 46; lines++) begin
            if (lines == 23) begin
                tx_idle_max = 0;
                rx_idle_max = 0;
            end
            if (lines == 0 || $urandom_range(0, 5) == 0) begin
                issue(OP_WRITE, reg_addr(WIN_IRQ, 1'b0),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5)),
                      14'($urandom));
                if ($urandom_range(0, 1) == 1)
                    issue(OP_WRITE, reg_addr(WIN_IRQ, 1'b1), 8'($urandom), 14'($urandom));
                issue(OP_WRITE, reg_addr(WIN_IRQ_EN, $urandom_range(0, 3) != 0), 8'($urandom),
                      14'($urandom));
            end
            repeat ($urandom_range(1, 3))
                issue(OP_LATCH, 16'($urandom), 8'($urandom),
                      {1'($urandom), 1'b1, 12'($urandom)});
            repeat ($urandom_range(0, 20)) begin
                issue(OP_LATCH, 16'($urandom), 8'($urandom),
                      {1'($urandom), 1'b0, 12'($urandom)});
                if ($urandom_range(0, 5) == 0) issue_random_access();
            end
            if (mp_irq_pend && $urandom_range(0, 1) == 1) begin
                issue(OP_WRITE, reg_addr(WIN_IRQ_EN, 1'b0), 8'($urandom), 14'($urandom));
                issue(OP_WRITE, reg_addr(WIN_IRQ_EN, 1'b1), 8'($urandom), 14'($urandom));
            end
        end
        tx_idle_max = 11;
        rx_idle_max = 11;
    endtask

    task automatic test_random_mix();
        repeat (500) issue_random_access();
    endtask

    task automatic test_backpressure();
        tx_idle_max = 0;
        long_hold = 120;
        repeat (80) issue_random_access();
        tx_idle_max = 11;
    endtask

    initial begin
        foreach (mp_bank[k]) mp_bank[k] = 8'h00;
        cfg_prg_log2 = PRG_SIZE_RST;
        cfg_chr_log2 = CHR_SIZE_RST;
        mp_bank_sel = '0;
        mp_prg_swap = 1'b0;
        mp_chr_swap = 1'b0;
        mp_irq_latch = '0;
        mp_irq_count = '0;
        mp_reload = 1'b0;
        mp_irq_en = 1'b0;
        mp_irq_pend = 1'b0;
        mp_a12_seen = 1'b0;
        mp_a12_timer = '0;
        mp_mirror_h = 1'b0;
        fail_count = 0;
        requests_sent = 0;
        cycle_count = 0;
        tx_idle_max = 11;
        rx_idle_max = 11;
        long_hold = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_READ;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_rom_sizes();
        test_scanline_irq();
        test_random_mix();
        test_backpressure();

        s_tvalid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
